// ===== src/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by the cell, the top level and the checker; depends on nothing.
`default_nettype none

package spq_pkg;

	localparam int DATA_W = 32;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with the pushed
// priority and shifts with its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire entry_t    new_entry,
	input  wire logic      occupied,
	input  wire logic      left_ge,
	input  wire entry_t    left_entry,
	input  wire entry_t    right_entry,
	output logic           ge,
	output entry_t         entry_q,
	output entry_t         entry_d
);

	// sorted descending, so ge is a prefix over the chain
	assign ge = occupied && (entry_q.prio >= new_entry.prio);

	always_comb begin
		entry_d = entry_q;
		if (ctl.push) begin
			if (!ge) begin
				entry_d = left_ge ? new_entry : left_entry;
			end
		end else if (ctl.pop) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue_core.sv =====
// Sorted priority queue: a row of CAPACITY cells kept in descending priority
// order, head in cell 0. Every cell compares its priority with the pushed one and
// shifts in the same cycle, so one push or pop word is taken per clock and its
// result word reaches the output register in the next cycle. The input stalls
// only while a result word is held because the output is stalled. Equal
// priorities leave in arrival order; a push when full or a pop when empty leaves
// the queue unchanged and reports it in status. No clearing pass after reset.
`default_nettype none

module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     kind,
	input  wire logic signed [DATA_W-1:0] item_value,
	input  wire logic signed [DATA_W-1:0] item_priority,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      head_value,
	output logic                          is_empty,
	output logic                          is_full,
	output logic [CNT_W-1:0]              entry_count,
	output logic [1:0]                    status
);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             out_valid_q;
	logic             accept;
	logic             full_now;
	logic             empty_now;
	status_t          status_d;
	cell_ctl_t        ctl;
	entry_t           new_entry;
	entry_t           cell_q [CAPACITY];
	entry_t           cell_d [CAPACITY];
	logic             cell_ge [CAPACITY];
	logic signed [DATA_W-1:0] head_q;
	logic             empty_q;
	logic             full_q;
	logic [CNT_W-1:0] count_out_q;
	status_t          status_q;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign full_now  = (count_q == CAP_CNT);
	assign empty_now = (count_q == '0);
	assign new_entry = '{value: item_value, prio: item_priority};

	always_comb begin
		ctl      = '0;
		status_d = ST_DONE;
		count_d  = count_q;
		if (kind == OP_PUSH) begin
			if (full_now) begin
				status_d = ST_FULL;
			end else begin
				ctl.push = accept;
				count_d  = count_q + 1'b1;
			end
		end else begin
			if (empty_now) begin
				status_d = ST_EMPTY;
			end else begin
				ctl.pop = accept;
				count_d = count_q - 1'b1;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic   left_ge;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_first
			assign left_ge    = 1'b1;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_ge    = cell_ge[i-1];
			assign left_entry = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = cell_q[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.occupied   (count_q > IDX),
			.left_ge    (left_ge),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.ge         (cell_ge[i]),
			.entry_q    (cell_q[i]),
			.entry_d    (cell_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_q      <= (count_d == '0) ? '0 : cell_d[0].value;
			empty_q     <= (count_d == '0);
			full_q      <= (count_d == CAP_CNT);
			count_out_q <= count_d;
			status_q    <= status_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign head_value  = head_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign entry_count = count_out_q;
	assign status      = status_q;

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_core.
`default_nettype none

module spq_checker
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_stall,
	input wire logic                     kind,
	input wire logic signed [DATA_W-1:0] item_value,
	input wire logic signed [DATA_W-1:0] item_priority,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic signed [DATA_W-1:0] head_value,
	input wire logic                     is_empty,
	input wire logic                     is_full,
	input wire logic [CNT_W-1:0]         entry_count,
	input wire logic [1:0]               status
);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)) && (!is_empty || head_value == '0))
		else $error("empty flag, count and head disagree");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_full == (entry_count == CAP_CNT)) && (entry_count <= CAP_CNT))
		else $error("full flag or count out of range");

	a_status_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != ST_FULL || is_full) && (status != ST_EMPTY || is_empty))
		else $error("status code disagrees with full or empty flag");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(item_value)
			&& $stable(item_priority))
		else $error("stalled input word changed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(head_value) && $stable(entry_count))
		else $error("stalled result word changed");

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

`default_nettype wire
